/* sv/bhmb_pkg.sv */
// ----------------------------------------------------------------------------
// Bloch hopping matrix builder package
// Shared types, command codes and fixed-point constants.
// ----------------------------------------------------------------------------
package bhmb_pkg;

  typedef enum logic [1:0] {
    CMD_START = 2'd0,
    CMD_LOAD  = 2'd1,
    CMD_EDGE  = 2'd2,
    CMD_READ  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    REG_A1_X = 2'd0,
    REG_A1_Y = 2'd1,
    REG_A2_X = 2'd2,
    REG_A2_Y = 2'd3
  } reg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_FETCH,
    ST_BOND,
    ST_PHASE,
    ST_REDUCE,
    ST_CORDIC,
    ST_MUL,
    ST_RD1,
    ST_WR1,
    ST_RD2,
    ST_WR2,
    ST_READ,
    ST_OUT
  } state_t;

  localparam logic signed [63:0] TWO_PI_Q16  = 64'sd411775;
  localparam logic signed [63:0] PI_Q16      = 64'sd205887;
  localparam logic signed [63:0] HALF_PI_Q16 = 64'sd102944;
  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
  // 2^50 divided by 2*pi in Q16.16 (1/(2*pi) scaled by 2^34), for the quotient estimate.
  localparam logic signed [63:0] RECIP_TWO_PI = (64'sd1 <<< 50) / TWO_PI_Q16;

  // Arctangent in Q2.30 for one CORDIC step.
  function automatic logic signed [33:0] atan_q30(input logic [5:0] i);
    logic signed [33:0] r;
    case (i)
      6'd0: r = 34'sd843314857;
      6'd1: r = 34'sd497837829;
      6'd2: r = 34'sd263043837;
      6'd3: r = 34'sd133525159;
      6'd4: r = 34'sd67021687;
      6'd5: r = 34'sd33543516;
      6'd6: r = 34'sd16775851;
      6'd7: r = 34'sd8388437;
      6'd8: r = 34'sd4194283;
      6'd9: r = 34'sd2097149;
      default: r = (i <= 6'd30) ? (34'sd1 <<< (6'd30 - i)) : 34'sd0;
    endcase
    return r;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) r = 32'sh7fffffff;
    else if (v < -64'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

endpackage

/* sv/bhmb_ram.sv */
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One write or one read per cycle, registered read data.
// ----------------------------------------------------------------------------
module bhmb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule

/* sv/bhmb_cordic.sv */
// ----------------------------------------------------------------------------
// Iterative CORDIC
// Rotation mode in Q2.30, one micro-rotation per cycle.
// ----------------------------------------------------------------------------
module bhmb_cordic #(
  parameter int STEPS = 24
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               go,
  input  logic signed [33:0] angle,
  output logic               done,
  output logic signed [33:0] cos_o,
  output logic signed [33:0] sin_o
);
  import bhmb_pkg::*;

  logic signed [33:0] x_r, y_r, z_r;
  logic [5:0] i_r;
  logic busy_r;

  assign cos_o = x_r;
  assign sin_o = y_r;
  assign done  = busy_r && (i_r == 6'(STEPS - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      i_r    <= '0;
    end else if (go) begin
      busy_r <= 1'b1;
      i_r    <= '0;
      x_r    <= CORDIC_GAIN;
      y_r    <= '0;
      z_r    <= angle;
    end else if (busy_r) begin
      if (z_r >= 0) begin
        x_r <= x_r - (y_r >>> i_r);
        y_r <= y_r + (x_r >>> i_r);
        z_r <= z_r - atan_q30(i_r);
      end else begin
        x_r <= x_r + (y_r >>> i_r);
        y_r <= y_r - (x_r >>> i_r);
        z_r <= z_r + atan_q30(i_r);
      end
      if (done) busy_r <= 1'b0;
      i_r <= i_r + 6'd1;
    end
  end
endmodule

/* sv/bloch_hopping_matrix_builder.sv */
// ----------------------------------------------------------------------------
// Bloch hopping matrix builder
// Accumulates a complex tight-binding Bloch matrix from edge commands.
// Edge: busy through fetch, bond, phase, reduction, CORDIC, multiply and both writes.
// Read: busy while the entry is read; it is strobed out once busy is low again.
// Start: busy while the matrix is swept to zero. Load: busy while a site is stored.
// One CORDIC and one-port RAM set the rate. Reset runs a clearing pass, busy high.
// ----------------------------------------------------------------------------
module bloch_hopping_matrix_builder #(
  parameter int MAX_SITES    = 16,
  parameter int CORDIC_STEPS = 24
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_cmd,
  input  logic [3:0]         in_index_a,
  input  logic [3:0]         in_index_b,
  input  logic signed [31:0] in_value_x,
  input  logic signed [31:0] in_value_y,
  input  logic signed [3:0]  in_cell_offset_1,
  input  logic signed [3:0]  in_cell_offset_2,
  input  logic signed [31:0] in_hop_weight,
  output logic               out_valid,
  output logic signed [31:0] out_entry_real,
  output logic signed [31:0] out_entry_imag,
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic [3:0]         cfg_paddr,
  input  logic [31:0]        cfg_pwdata,
  output logic [31:0]        cfg_prdata,
  output logic               cfg_pready
);
  import bhmb_pkg::*;

  localparam int SW = (MAX_SITES > 1) ? $clog2(MAX_SITES) : 1;
  localparam int MD = MAX_SITES * MAX_SITES;
  localparam int MW = (MD > 1) ? $clog2(MD) : 1;
  localparam int CW = (MW + 1 > 3) ? MW + 1 : 3;

  logic signed [31:0] a1x_r, a1y_r, a2x_r, a2y_r, kx_r, ky_r;
  state_t st_r, st_nxt;
  logic [1:0] cmd_r;
  logic [3:0] ia_r, ib_r;
  logic signed [31:0] vx_r, vy_r, w_r;
  logic signed [3:0] o1_r, o2_r;
  logic [CW-1:0] cnt_r;
  logic signed [31:0] rx_r, ry_r;
  logic signed [63:0] ph_r;
  logic signed [31:0] q_r;
  logic signed [33:0] ang_r;
  logic neg_r;
  logic signed [63:0] re_r, im_r;
  logic signed [31:0] pxa_r, pya_r;
  logic signed [31:0] out_re_r, out_im_r;
  logic out_v_r;

  // Config port
  logic cfg_wr;
  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a1x_r <= 32'sd65536; a1y_r <= '0; a2x_r <= '0; a2y_r <= 32'sd65536;
    end else if (cfg_wr) begin
      unique case (reg_idx_t'(cfg_paddr[3:2]))
        REG_A1_X: a1x_r <= cfg_pwdata;
        REG_A1_Y: a1y_r <= cfg_pwdata;
        REG_A2_X: a2x_r <= cfg_pwdata;
        REG_A2_Y: a2y_r <= cfg_pwdata;
        default: ;
      endcase
    end
  end
  always_comb begin
    unique case (reg_idx_t'(cfg_paddr[3:2]))
      REG_A1_X: cfg_prdata = a1x_r;
      REG_A1_Y: cfg_prdata = a1y_r;
      REG_A2_X: cfg_prdata = a2x_r;
      REG_A2_Y: cfg_prdata = a2y_r;
      default:  cfg_prdata = '0;
    endcase
  end

  // Site position RAMs
  logic pos_we;
  logic [SW-1:0] pos_addr;
  logic [31:0] pos_x_q, pos_y_q;
  bhmb_ram #(.WIDTH(32), .DEPTH(MAX_SITES)) u_posx (
    .clk(clk), .we(pos_we), .addr(pos_addr), .wdata(vx_r), .rdata(pos_x_q));
  bhmb_ram #(.WIDTH(32), .DEPTH(MAX_SITES)) u_posy (
    .clk(clk), .we(pos_we), .addr(pos_addr), .wdata(vy_r), .rdata(pos_y_q));

  // Matrix RAMs, real and imaginary halves side by side
  logic mat_we;
  logic [MW-1:0] mat_addr;
  logic [63:0] mat_wd, mat_q;
  bhmb_ram #(.WIDTH(64), .DEPTH(MD)) u_mat (
    .clk(clk), .we(mat_we), .addr(mat_addr), .wdata(mat_wd), .rdata(mat_q));

  // CORDIC
  logic cor_go, cor_done;
  logic signed [33:0] cor_c, cor_s;
  bhmb_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
    .clk(clk), .rst_n(rst_n), .go(cor_go), .angle(ang_r),
    .done(cor_done), .cos_o(cor_c), .sin_o(cor_s));

  logic acc;
  logic a_ok, b_ok;
  logic [MW-1:0] idx_ab, idx_ba;
  assign busy = (st_r != ST_IDLE);
  assign acc  = start && !busy;
  assign a_ok = 32'(ia_r) < MAX_SITES;
  assign b_ok = 32'(ib_r) < MAX_SITES;
  assign idx_ab = MW'(32'(ia_r) * MAX_SITES + 32'(ib_r));
  assign idx_ba = MW'(32'(ib_r) * MAX_SITES + 32'(ia_r));

  // Next state
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ST_IDLE: if (acc) begin
        unique case (cmd_t'(in_cmd))
          CMD_START: st_nxt = ST_CLEAR;
          CMD_LOAD:  st_nxt = ST_FETCH;
          CMD_EDGE:  st_nxt = ST_FETCH;
          CMD_READ:  st_nxt = ST_READ;
          default:   st_nxt = ST_IDLE;
        endcase
      end
      ST_CLEAR:  if (cnt_r == CW'(MD - 1)) st_nxt = ST_IDLE;
      ST_FETCH: begin
        if (cmd_r == CMD_LOAD) st_nxt = ST_IDLE;
        else if (!(a_ok && b_ok)) st_nxt = ST_IDLE;
        else if (cnt_r[0]) st_nxt = ST_BOND;
      end
      ST_BOND:   st_nxt = ST_PHASE;
      ST_PHASE:  st_nxt = ST_REDUCE;
      ST_REDUCE: if (cnt_r[2:0] == 3'd6) st_nxt = ST_CORDIC;
      ST_CORDIC: if (cor_done) st_nxt = ST_MUL;
      ST_MUL:    st_nxt = ST_RD1;
      ST_RD1:    if (cnt_r[0]) st_nxt = ST_WR1;
      ST_WR1:    st_nxt = ST_RD2;
      ST_RD2:    if (cnt_r[0]) st_nxt = ST_WR2;
      ST_WR2:    st_nxt = ST_IDLE;
      ST_READ:   if (cnt_r[0]) st_nxt = ST_OUT;
      ST_OUT:    st_nxt = ST_IDLE;
      default:   st_nxt = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    pos_we = 1'b0; pos_addr = ia_r[SW-1:0];
    mat_we = 1'b0; mat_addr = idx_ab; mat_wd = '0;
    cor_go = 1'b0;
    unique case (st_r)
      ST_CLEAR: begin mat_we = 1'b1; mat_addr = cnt_r[MW-1:0]; end
      ST_FETCH: begin
        if (cmd_r == CMD_LOAD) pos_we = a_ok;
        pos_addr = (cmd_r == CMD_LOAD || cnt_r[0]) ? ia_r[SW-1:0] : ib_r[SW-1:0];
      end
      ST_REDUCE: cor_go = (cnt_r[2:0] == 3'd6);
      ST_WR1: begin
        mat_we = 1'b1;
        mat_wd = {sat32(64'(signed'(mat_q[63:32])) + re_r),
                  sat32(64'(signed'(mat_q[31:0])) + im_r)};
      end
      ST_RD2: mat_addr = idx_ba;
      ST_WR2: begin
        mat_we = 1'b1; mat_addr = idx_ba;
        mat_wd = {sat32(64'(signed'(mat_q[63:32])) + re_r),
                  sat32(64'(signed'(mat_q[31:0])) - im_r)};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_CLEAR; cnt_r <= '0; out_v_r <= 1'b0;
      kx_r <= '0; ky_r <= '0;
    end else begin
      st_r <= st_nxt;
      out_v_r <= (st_r == ST_OUT);
      cnt_r <= (st_nxt != st_r) ? '0 : cnt_r + 1'b1;
      if (acc && cmd_t'(in_cmd) == CMD_START) begin
        kx_r <= in_value_x; ky_r <= in_value_y;
      end
    end
  end

  // Phase reduction helpers: upper phase bits for the quotient estimate,
  // and the fold of the reduced phase into [-pi/2, pi/2].
  logic signed [31:0] ph_hi;
  logic signed [63:0] fold_m;
  logic fold_neg;
  assign ph_hi = 32'(ph_r >>> 18);
  always_comb begin
    fold_m = ph_r;
    fold_neg = 1'b0;
    if (ph_r > HALF_PI_Q16) begin
      fold_m = ph_r - PI_Q16;
      fold_neg = 1'b1;
    end else if (ph_r < -HALF_PI_Q16) begin
      fold_m = ph_r + PI_Q16;
      fold_neg = 1'b1;
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (acc) begin
      cmd_r <= in_cmd; ia_r <= in_index_a; ib_r <= in_index_b;
      vx_r <= in_value_x; vy_r <= in_value_y; w_r <= in_hop_weight;
      o1_r <= in_cell_offset_1; o2_r <= in_cell_offset_2;
    end
    // Position of dst read first, then src.
    if (st_r == ST_FETCH && cnt_r[0]) begin
      pxa_r <= pos_x_q; pya_r <= pos_y_q;
    end
    if (st_r == ST_BOND) begin
      rx_r <= sat32(64'(signed'(pxa_r)) + 64'(o1_r) * 64'(a1x_r)
                    + 64'(o2_r) * 64'(a2x_r) - 64'(signed'(pos_x_q)));
      ry_r <= sat32(64'(signed'(pya_r)) + 64'(o1_r) * 64'(a1y_r)
                    + 64'(o2_r) * 64'(a2y_r) - 64'(signed'(pos_y_q)));
    end
    if (st_r == ST_PHASE)
      ph_r <= ((64'(kx_r) * 64'(rx_r)) >>> 16) + ((64'(ky_r) * 64'(ry_r)) >>> 16);
    if (st_r == ST_REDUCE) begin
      // The quotient estimate is at most two off, so the remainder lands in
      // (-2pi, 4pi) and one add and one subtract bring it into [0, 2pi).
      case (cnt_r[2:0])
        3'd0: q_r <= 32'((64'(ph_hi) * RECIP_TWO_PI) >>> 32);
        3'd1: ph_r <= ph_r - 64'(q_r) * TWO_PI_Q16;
        3'd2: if (ph_r < 0) ph_r <= ph_r + TWO_PI_Q16;
        3'd3: if (ph_r >= TWO_PI_Q16) ph_r <= ph_r - TWO_PI_Q16;
        3'd4: if (ph_r > PI_Q16) ph_r <= ph_r - TWO_PI_Q16;
        3'd5: begin
          neg_r <= fold_neg;
          ang_r <= 34'(fold_m <<< 14);
        end
        default: ;
      endcase
    end
    if (st_r == ST_MUL) begin
      re_r <= (64'(w_r) * 64'(neg_r ? -cor_c : cor_c) + (64'sd1 <<< 29)) >>> 30;
      im_r <= (64'(w_r) * 64'(neg_r ? -cor_s : cor_s) + (64'sd1 <<< 29)) >>> 30;
    end
    if (st_r == ST_READ && cnt_r[0]) begin
      out_re_r <= (a_ok && b_ok) ? mat_q[63:32] : '0;
      out_im_r <= (a_ok && b_ok) ? mat_q[31:0] : '0;
    end
  end

  assign out_valid      = out_v_r;
  assign out_entry_real = out_re_r;
  assign out_entry_imag = out_im_r;

  a_busy_acc: assert property (@(posedge clk) disable iff (!rst_n)
    acc |=> busy) else $error("accepted item did not raise busy");
  a_out_once: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result strobe longer than one cycle");
  a_cor_go: assert property (@(posedge clk) disable iff (!rst_n)
    cor_go |-> st_r == ST_REDUCE) else $error("CORDIC started outside reduction");
endmodule
